FILE: rtl/ftl_pkg.sv
// Shared types and constants for the page-mapped flash translation layer.
// No dependencies; imported by the top level.
package ftl_pkg;

  localparam int ADDR_SPAN = 1024;
  localparam int LAW       = 10;

  localparam logic [7:0] BLANK_BYTE = 8'h20;

  localparam logic [1:0] COND_INVALID = 2'd0;
  localparam logic [1:0] COND_ERASED  = 2'd1;
  localparam logic [1:0] COND_VALID   = 2'd2;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_LOG    = 2'd1;
  localparam logic [1:0] MODE_IDEAL  = 2'd2;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_LPC  = 3'd1;
  localparam logic [2:0] CFG_BC   = 3'd2;
  localparam logic [2:0] CFG_PPB  = 3'd3;
  localparam logic [2:0] CFG_GHI  = 3'd4;
  localparam logic [2:0] CFG_GLO  = 3'd5;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TRIM  = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_ILLEGAL  = 2'd2;
  localparam logic [1:0] STS_UNMAPPED = 2'd3;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_GEO_DIV, ST_GEO_WAIT, ST_GEO_NP, ST_CMD,
    ST_RD_L2P, ST_RD_OUT, ST_TRIM,
    ST_HW, ST_DIR_DIV, ST_DIR_BASE, ST_DIR_RD, ST_DIR_WR, ST_DIR_PROG,
    ST_LOG, ST_CLM_MUL, ST_CLM_RD, ST_CLM_CHK, ST_CLM_OK, ST_LOG_PROG, ST_LOG_DIV,
    ST_ER_MUL, ST_ER_LOOP, ST_POST, ST_OC_LOOP, ST_OC_END,
    ST_GC_DIV, ST_GC_WAIT, ST_GC_BLK, ST_GC_RD, ST_GC_CHK,
    ST_GC_S1, ST_GC_S2, ST_GC_S3, ST_GC_LIST,
    ST_GC_C1, ST_GC_C2, ST_GC_C3, ST_GC_CNEXT, ST_GC_NEXT, ST_DONE
  } fsm_e;

endpackage

FILE: rtl/ftl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                      wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                      rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ftl_div.sv
// Restoring divider, one quotient bit per cycle; quotient and remainder hold.
// No dependencies.
module ftl_div #(
  parameter int DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW:0]   rem_q, rem_d, shl;
  logic [DW-1:0] quo_q, quo_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    shl    = {rem_q[DW-1:0], quo_q[DW-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      if (shl >= {1'b0, den_q}) begin
        rem_d = shl - {1'b0, den_q};
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DW-1:0];

endmodule

FILE: rtl/flash_translation_layer_top.sv
// Page-mapped flash translation layer with garbage collection: top level and sequencer.
// Depends on ftl_pkg, ftl_ram and ftl_div.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tuser: action; tdata: address, write_data
//  m_axis    out        m_axis_tvalid/tready        tuser: status; tdata: read_data
//  cfg       in         cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// One command is handled at a time by a sequencer around one shared restoring
// divider, one shared multiplier and single-port-read RAMs. Every command first
// settles the geometry, then runs a read or trim, an ideal write, a direct write
// that divides and blanks the non-valid pages of its block, or a logging write
// that scans past rejected blocks, erases a never-used one before claiming it and
// divides after programming. The open-block count walks every block; collection
// reads each page of each victim, one host write per live page and an erase and count per victim.
// After reset a clearing pass over the page store and address span holds s_axis_tready low.
// A finished result waits in the output register; a new command may start meanwhile,
// and its result holds until the previous one is taken.
module flash_translation_layer_top
  import ftl_pkg::*;
#(
  parameter int PAGE_STORE  = 1024,
  parameter int BLOCK_STORE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] address, [17:10] write_data, zero pad
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] read_data
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int PW    = (PAGE_STORE > 1) ? $clog2(PAGE_STORE) : 1;
  localparam int PCW   = $clog2(PAGE_STORE + 1);
  localparam int BW    = (BLOCK_STORE > 1) ? $clog2(BLOCK_STORE) : 1;
  localparam int BCW   = $clog2(BLOCK_STORE + 1);
  localparam int DW    = (PCW > 11) ? PCW : 11;
  localparam int MW    = BCW + PCW;
  localparam int CLR_N = (PAGE_STORE > ADDR_SPAN) ? PAGE_STORE : ADDR_SPAN;
  localparam int CLW   = $clog2(CLR_N + 1);

  // configuration registers
  logic [1:0]  mode_q;
  logic [10:0] lpc_q, ppbr_q;
  logic [7:0]  bc_q, ghi_q, glo_q;

  fsm_e state_q, state_d;

  logic [1:0]   act_q, act_d, st_q, st_d, mst_q, mst_d;
  logic [9:0]   addr_q, addr_d, wa_q, wa_d;
  logic [7:0]   wdat_q, wdat_d, rd_q, rd_d, wd_q, wd_d, mrd_q, mrd_d;
  logic [PCW-1:0] ppb_q, ppb_d, np_q, np_d, base_q, base_d, k_q, k_d;
  logic [PCW-1:0] cur_q, cur_d, gfirst_q, gfirst_d, n_q, n_d, j_q, j_d;
  logic [BCW-1:0] nb_q, nb_d, scan_q, scan_d, gi_q, gi_d, oc_q, oc_d, ocb_q, ocb_d;
  logic [BW-1:0]  blk_q, blk_d, wblk_q, wblk_d, gcr_q, gcr_d, gb_q, gb_d;
  logic           in_gc_q, in_gc_d, er_claim_q, er_claim_d, cur_ok_q, cur_ok_d;
  logic           mv_q, mv_d;
  logic [BLOCK_STORE-1:0] bo_q, bo_d;
  logic [CLW-1:0] clr_q, clr_d;

  // memory ports
  logic            pg_we, l2p_we, p2l_we, lst_we;
  logic [PW-1:0]   pg_wa, pg_ra, p2l_wa, p2l_ra, lst_wa, lst_ra;
  logic [LAW-1:0]  l2p_wa, l2p_ra;
  logic [9:0]      pg_wd, pg_rd;
  logic [PW:0]     l2p_wd, l2p_rd;
  logic [LAW:0]    p2l_wd, p2l_rd;
  logic [PW-1:0]   lst_wd, lst_rd;

  // shared arithmetic
  logic            div_start, div_done;
  logic [DW-1:0]   div_n, div_d, div_q, div_r;
  logic [BCW-1:0]  mul_a;
  logic [MW-1:0]   mul_p;
  logic [PCW-1:0]  mul_lo, ppb_c, pg_idx, cur_inc, gpg;
  logic [31:0]     cap_w, n_w;
  logic [BW-1:0]   blk_nxt, gb_nxt;
  logic [1:0]      hw_sts;
  logic            hw_fin;

  assign mul_p   = MW'(mul_a) * MW'(ppb_q);
  assign mul_lo  = mul_p[PCW-1:0];
  assign pg_idx  = base_q + k_q;
  assign gpg     = gfirst_q + k_q;
  assign cur_inc = cur_q + 1'b1;
  assign blk_nxt = (32'(blk_q) + 32'd1 == 32'(nb_q)) ? '0 : blk_q + 1'b1;
  assign gb_nxt  = (32'(gb_q) + 32'd1 == 32'(nb_q)) ? '0 : gb_q + 1'b1;

  always_comb begin
    if (ppbr_q == '0) begin
      ppb_c = PCW'(1);
    end else if (32'(ppbr_q) > 32'(PAGE_STORE)) begin
      ppb_c = PCW'(PAGE_STORE);
    end else begin
      ppb_c = PCW'(ppbr_q);
    end
  end

  ftl_div #(.DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .done_o(div_done), .quo_o(div_q), .rem_o(div_r)
  );

  // page condition and byte
  ftl_ram #(.W(10), .D(PAGE_STORE)) u_pg (
    .clk_i, .we_i(pg_we), .waddr_i(pg_wa), .wdata_i(pg_wd),
    .raddr_i(pg_ra), .rdata_o(pg_rd)
  );
  // forward map: valid, physical page
  ftl_ram #(.W(PW + 1), .D(ADDR_SPAN)) u_l2p (
    .clk_i, .we_i(l2p_we), .waddr_i(l2p_wa), .wdata_i(l2p_wd),
    .raddr_i(l2p_ra), .rdata_o(l2p_rd)
  );
  // reverse map: valid, logical page
  ftl_ram #(.W(LAW + 1), .D(PAGE_STORE)) u_p2l (
    .clk_i, .we_i(p2l_we), .waddr_i(p2l_wa), .wdata_i(p2l_wd),
    .raddr_i(p2l_ra), .rdata_o(p2l_rd)
  );
  // live pages of the current victim
  ftl_ram #(.W(PW), .D(PAGE_STORE)) u_lst (
    .clk_i, .we_i(lst_we), .waddr_i(lst_wa), .wdata_i(lst_wd),
    .raddr_i(lst_ra), .rdata_o(lst_rd)
  );

  always_comb begin
    state_d = state_q;
    act_d = act_q; addr_d = addr_q; wdat_d = wdat_q; st_d = st_q; rd_d = rd_q;
    ppb_d = ppb_q; nb_d = nb_q; np_d = np_q; in_gc_d = in_gc_q; er_claim_d = er_claim_q;
    wa_d = wa_q; wd_d = wd_q; blk_d = blk_q; base_d = base_q; k_d = k_q; scan_d = scan_q;
    cur_d = cur_q; cur_ok_d = cur_ok_q; wblk_d = wblk_q; gcr_d = gcr_q; gb_d = gb_q;
    gi_d = gi_q; gfirst_d = gfirst_q; n_d = n_q; j_d = j_q; oc_d = oc_q; ocb_d = ocb_q;
    bo_d = bo_q; clr_d = clr_q;
    mv_d = mv_q & ~m_axis_tready; mst_d = mst_q; mrd_d = mrd_q;

    pg_we = 1'b0; pg_wa = '0; pg_wd = '0; pg_ra = '0;
    l2p_we = 1'b0; l2p_wa = '0; l2p_wd = '0; l2p_ra = '0;
    p2l_we = 1'b0; p2l_wa = '0; p2l_wd = '0; p2l_ra = '0;
    lst_we = 1'b0; lst_wa = '0; lst_wd = '0; lst_ra = '0;
    div_start = 1'b0; div_n = '0; div_d = '0; mul_a = '0;
    cap_w = '0; n_w = '0;
    hw_fin = 1'b0; hw_sts = STS_OK;

    case (state_q)
      ST_CLEAR: begin
        pg_we  = (32'(clr_q) < 32'(PAGE_STORE));
        pg_wa  = PW'(clr_q);
        pg_wd  = {COND_INVALID, BLANK_BYTE};
        p2l_we = pg_we;
        p2l_wa = PW'(clr_q);
        p2l_wd = '0;
        l2p_we = (32'(clr_q) < 32'(ADDR_SPAN));
        l2p_wa = LAW'(clr_q);
        l2p_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (32'(clr_q) == 32'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d   = s_axis_tuser;
          addr_d  = s_axis_tdata[9:0];
          wdat_d  = s_axis_tdata[17:10];
          st_d    = STS_OK;
          rd_d    = '0;
          in_gc_d = 1'b0;
          state_d = ST_GEO_DIV;
        end
      end
      ST_GEO_DIV: begin
        ppb_d     = ppb_c;
        div_start = 1'b1;
        div_n     = DW'(PAGE_STORE);
        div_d     = DW'(ppb_c);
        state_d   = ST_GEO_WAIT;
      end
      ST_GEO_WAIT: begin
        if (div_done) begin
          cap_w   = (32'(div_q) > 32'(BLOCK_STORE)) ? 32'(BLOCK_STORE) : 32'(div_q);
          n_w     = (32'(bc_q) < cap_w) ? 32'(bc_q) : cap_w;
          nb_d    = (n_w == 32'd0) ? BCW'(1) : BCW'(n_w);
          state_d = ST_GEO_NP;
        end
      end
      ST_GEO_NP: begin
        mul_a   = nb_q;
        np_d    = mul_lo;
        state_d = ST_CMD;
      end
      ST_CMD: begin
        case (act_q)
          ACT_READ, ACT_TRIM: begin
            if ({1'b0, addr_q} >= lpc_q) begin
              st_d    = STS_ILLEGAL;
              state_d = ST_POST;
            end else begin
              l2p_ra  = addr_q;
              state_d = (act_q == ACT_READ) ? ST_RD_L2P : ST_TRIM;
            end
          end
          ACT_WRITE: begin
            wa_d    = addr_q;
            wd_d    = wdat_q;
            state_d = ST_HW;
          end
          default: state_d = ST_POST;
        endcase
      end
      ST_RD_L2P: begin
        if (!l2p_rd[PW]) begin
          st_d    = STS_UNMAPPED;
          state_d = ST_POST;
        end else begin
          pg_ra   = l2p_rd[PW-1:0];
          state_d = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        rd_d    = pg_rd[7:0];
        state_d = ST_POST;
      end
      ST_TRIM: begin
        if (!l2p_rd[PW]) begin
          st_d = STS_UNMAPPED;
        end else begin
          l2p_we = 1'b1;
          l2p_wa = addr_q;
          l2p_wd = {1'b0, l2p_rd[PW-1:0]};
        end
        state_d = ST_POST;
      end

      // host write, entered from a command or from a collection copy
      ST_HW: begin
        if ({1'b0, wa_q} >= lpc_q) begin
          hw_fin = 1'b1;
          hw_sts = STS_ILLEGAL;
        end else if (mode_q == MODE_DIRECT || mode_q == MODE_IDEAL) begin
          if (32'(wa_q) >= 32'(np_q)) begin
            hw_fin = 1'b1;
            hw_sts = STS_ILLEGAL;
          end else if (mode_q == MODE_IDEAL) begin
            pg_we  = 1'b1; pg_wa = PW'(wa_q); pg_wd = {COND_VALID, wd_q};
            l2p_we = 1'b1; l2p_wa = wa_q; l2p_wd = {1'b1, PW'(wa_q)};
            p2l_we = 1'b1; p2l_wa = PW'(wa_q); p2l_wd = {1'b1, wa_q};
            hw_fin = 1'b1;
          end else begin
            div_start = 1'b1;
            div_n     = DW'(wa_q);
            div_d     = DW'(ppb_q);
            state_d   = ST_DIR_DIV;
          end
        end else begin
          state_d = ST_LOG;
        end
      end
      ST_DIR_DIV: begin
        if (div_done) begin
          blk_d   = BW'(div_q);
          state_d = ST_DIR_BASE;
        end
      end
      ST_DIR_BASE: begin
        mul_a   = BCW'(blk_q);
        base_d  = mul_lo;
        k_d     = '0;
        state_d = ST_DIR_RD;
      end
      ST_DIR_RD: begin
        if (k_q == ppb_q) begin
          state_d = ST_DIR_PROG;
        end else begin
          pg_ra   = PW'(pg_idx);
          state_d = ST_DIR_WR;
        end
      end
      ST_DIR_WR: begin
        // blank every page of the block that holds no valid data
        if (pg_rd[9:8] != COND_VALID) begin
          pg_we = 1'b1;
          pg_wa = PW'(pg_idx);
          pg_wd = {COND_ERASED, BLANK_BYTE};
        end
        k_d     = k_q + 1'b1;
        state_d = ST_DIR_RD;
      end
      ST_DIR_PROG: begin
        bo_d[blk_q] = 1'b0;
        pg_we  = 1'b1; pg_wa = PW'(wa_q); pg_wd = {COND_VALID, wd_q};
        l2p_we = 1'b1; l2p_wa = wa_q; l2p_wd = {1'b1, PW'(wa_q)};
        p2l_we = 1'b1; p2l_wa = PW'(wa_q); p2l_wd = {1'b1, wa_q};
        hw_fin = 1'b1;
      end
      ST_LOG: begin
        if (cur_ok_q && cur_q < np_q) begin
          state_d = ST_LOG_PROG;
        end else begin
          cur_ok_d = 1'b0;
          blk_d    = (32'(wblk_q) < 32'(nb_q)) ? wblk_q : '0;
          scan_d   = '0;
          state_d  = ST_CLM_MUL;
        end
      end
      ST_CLM_MUL: begin
        if (scan_q == nb_q) begin
          hw_fin = 1'b1;
          hw_sts = STS_FULL;
        end else begin
          mul_a   = BCW'(blk_q);
          base_d  = mul_lo;
          state_d = ST_CLM_RD;
        end
      end
      ST_CLM_RD: begin
        pg_ra   = PW'(base_q);
        state_d = ST_CLM_CHK;
      end
      ST_CLM_CHK: begin
        if (pg_rd[9:8] == COND_VALID) begin
          scan_d  = scan_q + 1'b1;
          blk_d   = blk_nxt;
          state_d = ST_CLM_MUL;
        end else if (pg_rd[9:8] == COND_INVALID) begin
          // never-used block: erase before claiming
          er_claim_d = 1'b1;
          k_d        = '0;
          state_d    = ST_ER_LOOP;
        end else begin
          state_d = ST_CLM_OK;
        end
      end
      ST_CLM_OK: begin
        wblk_d      = blk_q;
        cur_d       = base_q;
        cur_ok_d    = 1'b1;
        bo_d[blk_q] = 1'b1;
        state_d     = ST_LOG_PROG;
      end
      ST_LOG_PROG: begin
        pg_we  = 1'b1; pg_wa = PW'(cur_q); pg_wd = {COND_VALID, wd_q};
        l2p_we = 1'b1; l2p_wa = wa_q; l2p_wd = {1'b1, PW'(cur_q)};
        p2l_we = 1'b1; p2l_wa = PW'(cur_q); p2l_wd = {1'b1, wa_q};
        cur_d     = cur_inc;
        div_start = 1'b1;
        div_n     = DW'(cur_inc);
        div_d     = DW'(ppb_q);
        state_d   = ST_LOG_DIV;
      end
      ST_LOG_DIV: begin
        if (div_done) begin
          // close the cursor at a block boundary or the end of the store
          if (div_r == '0 || cur_q >= np_q) begin
            cur_ok_d = 1'b0;
          end
          hw_fin = 1'b1;
        end
      end

      // block erase, from a claim or from collection
      ST_ER_MUL: begin
        mul_a   = BCW'(blk_q);
        base_d  = mul_lo;
        k_d     = '0;
        state_d = ST_ER_LOOP;
      end
      ST_ER_LOOP: begin
        if (k_q == ppb_q) begin
          bo_d[blk_q] = 1'b0;
          er_claim_d  = 1'b0;
          if (er_claim_q) begin
            state_d = ST_CLM_OK;
          end else begin
            oc_d    = '0;
            ocb_d   = '0;
            state_d = ST_OC_LOOP;
          end
        end else begin
          pg_we   = 1'b1;
          pg_wa   = PW'(pg_idx);
          pg_wd   = {COND_ERASED, BLANK_BYTE};
          k_d     = k_q + 1'b1;
        end
      end

      // open-block count after a command or a collection erase
      ST_POST: begin
        oc_d    = '0;
        ocb_d   = '0;
        state_d = ST_OC_LOOP;
      end
      ST_OC_LOOP: begin
        if (ocb_q == nb_q) begin
          state_d = ST_OC_END;
        end else begin
          oc_d  = oc_q + BCW'(bo_q[ocb_q[BW-1:0]]);
          ocb_d = ocb_q + 1'b1;
        end
      end
      ST_OC_END: begin
        if (in_gc_q) begin
          if (32'(oc_q) <= 32'(glo_q)) begin
            gcr_d   = gb_q;
            state_d = ST_DONE;
          end else begin
            state_d = ST_GC_NEXT;
          end
        end else if (32'(oc_q) >= 32'(ghi_q)) begin
          in_gc_d = 1'b1;
          state_d = ST_GC_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end

      // garbage collection
      ST_GC_DIV: begin
        div_start = 1'b1;
        div_n     = DW'(gcr_q);
        div_d     = DW'(nb_q);
        state_d   = ST_GC_WAIT;
      end
      ST_GC_WAIT: begin
        if (div_done) begin
          gb_d    = BW'(div_r);
          gi_d    = '0;
          state_d = ST_GC_BLK;
        end
      end
      ST_GC_BLK: begin
        if (gi_q == nb_q) begin
          state_d = ST_DONE;
        end else if (gb_q == wblk_q) begin
          state_d = ST_GC_NEXT;
        end else begin
          mul_a    = BCW'(gb_q);
          gfirst_d = mul_lo;
          state_d  = ST_GC_RD;
        end
      end
      ST_GC_RD: begin
        pg_ra   = PW'(gfirst_q);
        state_d = ST_GC_CHK;
      end
      ST_GC_CHK: begin
        if (pg_rd[9:8] == COND_ERASED) begin
          state_d = ST_GC_NEXT;
        end else begin
          k_d     = '0;
          n_d     = '0;
          state_d = ST_GC_S1;
        end
      end
      ST_GC_S1: begin
        if (k_q == ppb_q) begin
          state_d = ST_GC_LIST;
        end else begin
          p2l_ra  = PW'(gpg);
          state_d = ST_GC_S2;
        end
      end
      ST_GC_S2: begin
        if (!p2l_rd[LAW]) begin
          k_d     = k_q + 1'b1;
          state_d = ST_GC_S1;
        end else begin
          l2p_ra  = p2l_rd[LAW-1:0];
          state_d = ST_GC_S3;
        end
      end
      ST_GC_S3: begin
        // live when the forward map still points back at this page
        if (l2p_rd[PW] && l2p_rd[PW-1:0] == PW'(gpg)) begin
          lst_we = 1'b1;
          lst_wa = PW'(n_q);
          lst_wd = PW'(gpg);
          n_d    = n_q + 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = ST_GC_S1;
      end
      ST_GC_LIST: begin
        if (n_q == ppb_q) begin
          state_d = ST_GC_NEXT;
        end else begin
          j_d     = '0;
          state_d = ST_GC_C1;
        end
      end
      ST_GC_C1: begin
        if (j_q == n_q) begin
          blk_d      = gb_q;
          er_claim_d = 1'b0;
          state_d    = ST_ER_MUL;
        end else begin
          lst_ra  = PW'(j_q);
          state_d = ST_GC_C2;
        end
      end
      ST_GC_C2: begin
        pg_ra   = lst_rd;
        p2l_ra  = lst_rd;
        state_d = ST_GC_C3;
      end
      ST_GC_C3: begin
        wa_d    = p2l_rd[LAW-1:0];
        wd_d    = pg_rd[7:0];
        state_d = ST_HW;
      end
      ST_GC_CNEXT: begin
        j_d     = j_q + 1'b1;
        state_d = ST_GC_C1;
      end
      ST_GC_NEXT: begin
        gi_d    = gi_q + 1'b1;
        gb_d    = gb_nxt;
        state_d = ST_GC_BLK;
      end
      ST_DONE: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          mst_d   = st_q;
          mrd_d   = rd_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // return from a host write: status only counts for the host command
    if (hw_fin) begin
      if (!in_gc_q) begin
        st_d = hw_sts;
      end
      state_d = in_gc_q ? ST_GC_CNEXT : ST_POST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      mode_q     <= MODE_DIRECT;
      lpc_q      <= 11'd50;
      bc_q       <= 8'd7;
      ppbr_q     <= 11'd10;
      ghi_q      <= 8'd10;
      glo_q      <= 8'd8;
      bo_q       <= '0;
      cur_ok_q   <= 1'b0;
      wblk_q     <= '0;
      gcr_q      <= '0;
      in_gc_q    <= 1'b0;
      er_claim_q <= 1'b0;
      mv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      bo_q       <= bo_d;
      cur_ok_q   <= cur_ok_d;
      wblk_q     <= wblk_d;
      gcr_q      <= gcr_d;
      in_gc_q    <= in_gc_d;
      er_claim_q <= er_claim_d;
      mv_q       <= mv_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_data_i[1:0];
          CFG_LPC:  lpc_q  <= cfg_data_i;
          CFG_BC:   bc_q   <= cfg_data_i[7:0];
          CFG_PPB:  ppbr_q <= cfg_data_i;
          CFG_GHI:  ghi_q  <= cfg_data_i[7:0];
          CFG_GLO:  glo_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    addr_q   <= addr_d;
    wdat_q   <= wdat_d;
    st_q     <= st_d;
    rd_q     <= rd_d;
    ppb_q    <= ppb_d;
    nb_q     <= nb_d;
    np_q     <= np_d;
    wa_q     <= wa_d;
    wd_q     <= wd_d;
    blk_q    <= blk_d;
    base_q   <= base_d;
    k_q      <= k_d;
    scan_q   <= scan_d;
    cur_q    <= cur_d;
    gb_q     <= gb_d;
    gi_q     <= gi_d;
    gfirst_q <= gfirst_d;
    n_q      <= n_d;
    j_q      <= j_d;
    oc_q     <= oc_d;
    ocb_q    <= ocb_d;
    mst_q    <= mst_d;
    mrd_q    <= mrd_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mrd_q;
  assign m_axis_tuser  = mst_q;

`ifndef SYNTH
  // an open cursor between commands always points inside the page store
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cur_ok_q) |-> (32'(cur_q) < 32'(PAGE_STORE)))
    else $error("write cursor open beyond the page store");

  // geometry is settled before a command is dispatched
  a_geometry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMD) |-> (nb_q != '0 && 32'(np_q) <= 32'(PAGE_STORE)))
    else $error("block geometry out of range");

  // one command at a time: no second transaction right after an accepted one
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a command is in progress");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for flash_translation_layer_top: directed and random host commands
// over several geometry and policy settings, checked against a shadow translation layer.
// Depends on ftl_pkg and the RTL of the block only.
module testbench;
  import ftl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES     = 1024;
  localparam int BLOCKS    = 128;
  localparam int CYCLE_CAP = 20_000_000;

  typedef struct {
    logic [1:0] status;
    logic [7:0] rdata;
  } reply_t;

  // Shadow copy of the translation layer: maps, page store, cursor and collector state.
  class FtlShadow;
    int unsigned mode, lpc, bc, ppb_reg, ghi, glo;
    logic [1:0]  cond[PAGES];
    logic [7:0]  bytes[PAGES];
    int unsigned l2p[ADDR_SPAN];
    bit          l2p_ok[ADDR_SPAN];
    int unsigned p2l[PAGES];
    bit          p2l_ok[PAGES];
    bit          blk_open[BLOCKS];
    int unsigned cursor, wblock, resume;
    bit          cursor_ok;
    reply_t      expected_replies[$];

    function void clear();
      mode = MODE_DIRECT; lpc = 50; bc = 7; ppb_reg = 10; ghi = 10; glo = 8;
      for (int i = 0; i < PAGES; i++) begin
        cond[i] = COND_INVALID; bytes[i] = BLANK_BYTE; p2l[i] = 0; p2l_ok[i] = 0;
      end
      for (int i = 0; i < ADDR_SPAN; i++) begin
        l2p[i] = 0; l2p_ok[i] = 0;
      end
      foreach (blk_open[i]) blk_open[i] = 0;
      cursor = 0; cursor_ok = 0; wblock = 0; resume = 0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned val);
      case (idx)
        CFG_MODE: mode = val & 3;
        CFG_LPC:  lpc = val & 11'h7ff;
        CFG_BC:   bc = val & 8'hff;
        CFG_PPB:  ppb_reg = val & 11'h7ff;
        CFG_GHI:  ghi = val & 8'hff;
        CFG_GLO:  glo = val & 8'hff;
        default: ;
      endcase
    endfunction

    function int unsigned ppb();
      if (ppb_reg < 1) return 1;
      if (ppb_reg > PAGES) return PAGES;
      return ppb_reg;
    endfunction

    function int unsigned nblocks();
      int unsigned cap, n;
      cap = PAGES / ppb();
      n = bc;
      if (cap > BLOCKS) cap = BLOCKS;
      if (n > cap) n = cap;
      if (n < 1) n = 1;
      return n;
    endfunction

    function void erase_block(int unsigned b);
      int unsigned base;
      base = b * ppb();
      for (int unsigned k = 0; k < ppb(); k++)
        if (base + k < PAGES) begin
          bytes[base + k] = BLANK_BYTE; cond[base + k] = COND_ERASED;
        end
      if (b < BLOCKS) blk_open[b] = 0;
    endfunction

    function void program_page(int unsigned p, logic [7:0] d);
      if (p < PAGES) begin
        bytes[p] = d; cond[p] = COND_VALID;
      end
    endfunction

    function int unsigned open_count();
      int unsigned n;
      n = 0;
      for (int unsigned b = 0; b < nblocks(); b++) n += blk_open[b];
      return n;
    endfunction

    function void map_identity(int unsigned a);
      l2p[a] = a; l2p_ok[a] = 1; p2l[a] = a; p2l_ok[a] = 1;
    endfunction

    function void write_in_place(int unsigned a, logic [7:0] d);
      int unsigned b, base;
      b = a / ppb();
      base = b * ppb();
      for (int unsigned k = 0; k < ppb(); k++)
        if (base + k < PAGES && cond[base + k] != COND_VALID) begin
          bytes[base + k] = BLANK_BYTE; cond[base + k] = COND_ERASED;
        end
      if (b < BLOCKS) blk_open[b] = 0;
      program_page(a, d);
      map_identity(a);
    endfunction

    function bit claim_block(int unsigned b);
      int unsigned first;
      first = b * ppb();
      if (first >= PAGES || cond[first] == COND_VALID) return 0;
      if (cond[first] == COND_INVALID) erase_block(b);
      wblock = b; cursor = first; cursor_ok = 1; blk_open[b] = 1;
      return 1;
    endfunction

    function logic [1:0] append_page(int unsigned a, logic [7:0] d);
      int unsigned nb, np, start;
      nb = nblocks();
      np = nb * ppb();
      if (cursor_ok && cursor >= np) cursor_ok = 0;
      if (!cursor_ok) begin
        start = (wblock < nb) ? wblock : 0;
        for (int unsigned i = 0; i < nb; i++)
          if (claim_block((start + i) % nb)) break;
        if (!cursor_ok) return STS_FULL;
      end
      program_page(cursor, d);
      l2p[a] = cursor; l2p_ok[a] = 1; p2l[cursor] = a; p2l_ok[cursor] = 1;
      cursor++;
      if (cursor % ppb() == 0 || cursor >= np) cursor_ok = 0;
      return STS_OK;
    endfunction

    function logic [1:0] host_write(int unsigned a, logic [7:0] d);
      if (a >= lpc || a >= ADDR_SPAN) return STS_ILLEGAL;
      if (mode == MODE_DIRECT || mode == MODE_IDEAL) begin
        if (a >= nblocks() * ppb()) return STS_ILLEGAL;
        if (mode == MODE_DIRECT) write_in_place(a, d);
        else begin
          program_page(a, d); map_identity(a);
        end
        return STS_OK;
      end
      return append_page(a, d);
    endfunction

    // Relocate live pages out of partly live blocks until enough blocks are closed.
    function void collect_garbage();
      int unsigned nb, b, first, lg;
      int unsigned live[$];
      logic [1:0] dropped;
      nb = nblocks();
      for (int unsigned i = 0; i < nb; i++) begin
        b = (resume + i) % nb;
        first = b * ppb();
        if (b == wblock || cond[first] == COND_ERASED) continue;
        live.delete();
        for (int unsigned k = 0; k < ppb(); k++) begin
          if (!p2l_ok[first + k]) continue;
          lg = p2l[first + k] & (ADDR_SPAN - 1);
          if (l2p_ok[lg] && l2p[lg] == first + k) live.push_back(first + k);
        end
        if (live.size() == ppb()) continue;
        foreach (live[k]) dropped = host_write(p2l[live[k]], bytes[live[k]]);
        erase_block(b);
        if (open_count() <= glo) begin
          resume = b;
          return;
        end
      end
    endfunction

    function void note_command(logic [1:0] act, int unsigned a, logic [7:0] d);
      reply_t r;
      r.status = STS_OK;
      r.rdata = 8'h00;
      case (act)
        ACT_READ:
          if (a >= lpc) r.status = STS_ILLEGAL;
          else if (!l2p_ok[a]) r.status = STS_UNMAPPED;
          else r.rdata = bytes[l2p[a]];
        ACT_WRITE: r.status = host_write(a, d);
        ACT_TRIM:
          if (a >= lpc) r.status = STS_ILLEGAL;
          else if (!l2p_ok[a]) r.status = STS_UNMAPPED;
          else l2p_ok[a] = 0;
        default: ;
      endcase
      if (open_count() >= ghi) collect_garbage();
      expected_replies.push_back(r);
    endfunction

    function string check_response(logic [1:0] st, logic [7:0] rd);
      reply_t r;
      if (expected_replies.size() == 0)
        return $sformatf("unexpected response status %0d data %02h", st, rd);
      r = expected_replies.pop_front();
      if (st !== r.status)
        return $sformatf("status %0d, expected %0d", st, r.status);
      if (rd !== r.rdata)
        return $sformatf("read data %02h, expected %02h", rd, r.rdata);
      return "";
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;

  FtlShadow    shadow = new();
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int          hold_cycles = 0; // long receiver hold-off, counted down by the receiver

  flash_translation_layer_top DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: covers the clearing pass, the slowest collections and long stalls.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  // Receiver side: honor a pending hold-off, else stall at the rate of the idle mode.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == 2)
      m_axis_tready <= ($urandom_range(99) >= 70);
    else if (idle_mode == 3)
      m_axis_tready <= ($urandom_range(99) >= 15);
    else
      m_axis_tready <= 1'b1;
  end

  // Check every response transaction against the oldest expected reply.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      msg = shadow.check_response(m_axis_tuser, m_axis_tdata);
      if (msg != "") report_mismatch(msg);
    end
  end

  function automatic bit sender_idles();
    if (idle_mode == 1) return $urandom_range(99) < 70;
    if (idle_mode == 3) return $urandom_range(99) < 15;
    return 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the command is taken.
  // Valid stays high on return so back-to-back commands see no bubble.
  task automatic send_command(logic [1:0] act, logic [9:0] a, logic [7:0] d);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, d, a};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_command(act, a, d);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    shadow.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(int m, int lpc, int bc, int ppb, int ghi, int glo);
    write_reg(CFG_MODE, m);
    write_reg(CFG_LPC, lpc);
    write_reg(CFG_BC, bc);
    write_reg(CFG_PPB, ppb);
    write_reg(CFG_GHI, ghi);
    write_reg(CFG_GLO, glo);
  endtask

  // Drop valid, wait for every reply, then let the sequencer settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  // Mostly addresses inside the legal range, so maps fill up and collection runs.
  task automatic random_commands(int n);
    int unsigned hi, pick;
    logic [1:0]  act;
    logic [9:0]  a;
    hi = (shadow.lpc > ADDR_SPAN) ? ADDR_SPAN - 1 : ((shadow.lpc == 0) ? 0 : shadow.lpc - 1);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) act = ACT_WRITE;
      else if (pick < 80) act = ACT_READ;
      else if (pick < 93) act = ACT_TRIM;
      else act = 2'd3;
      a = ($urandom_range(99) < 85) ? 10'($urandom_range(hi)) : 10'($urandom_range(1023));
      send_command(act, a, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    shadow.clear();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Direct mode; logical range wider than the physical store.
    configure(MODE_DIRECT, 100, 7, 10, 10, 8);
    send_command(ACT_READ, 10'd0, 8'h00);      // unmapped read
    send_command(ACT_TRIM, 10'd0, 8'h00);      // unmapped trim
    send_command(ACT_WRITE, 10'd0, 8'h00);
    send_command(ACT_WRITE, 10'd69, 8'hff);    // last physical page
    send_command(ACT_WRITE, 10'd70, 8'h11);    // legal address beyond the store
    send_command(ACT_WRITE, 10'd100, 8'h22);   // first illegal address
    send_command(ACT_READ, 10'd0, 8'h00);
    send_command(ACT_READ, 10'd69, 8'h00);
    send_command(ACT_READ, 10'd1023, 8'h00);   // illegal read
    send_command(ACT_TRIM, 10'd1023, 8'h00);   // illegal trim
    send_command(2'd3, 10'd1023, 8'hff);       // undefined action
    send_command(ACT_TRIM, 10'd0, 8'h00);
    send_command(ACT_READ, 10'd0, 8'h00);      // trimmed page reads unmapped
    send_command(ACT_WRITE, 10'd5, 8'haa);
    send_command(ACT_WRITE, 10'd6, 8'h55);     // same erase block, keeps page 5
    send_command(ACT_READ, 10'd5, 8'h00);
    send_command(ACT_READ, 10'd6, 8'h00);
    random_commands(60);
    drain();

    // Logging with a low collection threshold; hold the receiver off so the block backs up.
    idle_mode = 1;
    configure(MODE_LOG, 60, 8, 8, 5, 3);
    hold_cycles = 3000;
    random_commands(140);
    drain();

    // Ideal mapping at the largest sizes; block count clamps to one.
    idle_mode = 2;
    configure(MODE_IDEAL, 1024, 128, 1024, 128, 0);
    random_commands(60);
    drain();

    // Mode three behaves as logging; a single one-page block fills at once.
    idle_mode = 3;
    configure(3, 1, 1, 1, 1, 0);
    random_commands(40);
    drain();

    // Logging over many small blocks; block count clamps to the block store.
    idle_mode = 0;
    configure(MODE_LOG, 200, 200, 4, 6, 2);
    random_commands(140);
    drain();

    // Collection after every command.
    idle_mode = 1;
    configure(MODE_LOG, 40, 6, 5, 0, 0);
    random_commands(80);
    drain();

    // Zero geometry clamps to one page; all addresses legal, marks at their top.
    idle_mode = 2;
    configure(MODE_DIRECT, 2047, 0, 0, 255, 255);
    random_commands(40);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
